@@ rtl/ipid_pkg.sv @@
// Shared types, widths and register indexes for the incremental PID step.
package ipid_pkg;

  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned DataW   = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned Diff1W  = 18;
  localparam int unsigned Diff2W  = 19;
  localparam int unsigned InnerW  = 37;
  localparam int unsigned LoW     = 18;
  localparam int unsigned SumW    = 54;
  localparam int unsigned AccW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned MulW    = 20;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN        = 2'd0,
    REG_INTEGRAL_RATIO   = 2'd1,
    REG_DERIVATIVE_RATIO = 2'd2,
    REG_LIMIT_MAGNITUDE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KI,
    ST_KD,
    ST_IADD,
    ST_LO,
    ST_HI,
    ST_HADD,
    ST_CLAMP
  } state_e;

  typedef enum logic [1:0] {
    MUL_KI_ERR,
    MUL_KD_CURV,
    MUL_KP_LO,
    MUL_KP_HI
  } mul_sel_e;

  typedef struct packed {
    logic     busy;
    mul_sel_e mul_sel;
    logic     inner_load;
    logic     inner_add;
    logic     sum_load;
    logic     sum_add_lo;
    logic     sum_add_hi;
    logic     commit;
  } ctrl_t;

endpackage

@@ rtl/ipid_mul.sv @@
// Shared signed multiplier with a registered product.
module ipid_mul (
  input  logic                                clk_i,
  input  logic signed [ipid_pkg::MulW-1:0]    a_i,
  input  logic signed [ipid_pkg::MulW-1:0]    b_i,
  output logic signed [ipid_pkg::ProdW-1:0]   prod_o
);
  import ipid_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/ipid_ctrl.sv @@
// Sequencer that steps one item through the shared multiplier.
module ipid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_busy_i,
  output ipid_pkg::ctrl_t ctrl_o
);
  import ipid_pkg::*;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_KI;
      ST_KI:    state_d = ST_KD;
      ST_KD:    state_d = ST_IADD;
      ST_IADD:  state_d = ST_LO;
      ST_LO:    state_d = ST_HI;
      ST_HI:    state_d = ST_HADD;
      ST_HADD:  state_d = ST_CLAMP;
      ST_CLAMP: if (!out_busy_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.busy       = (state_q != ST_IDLE);
    ctrl_o.mul_sel    = MUL_KI_ERR;
    unique case (state_q)
      ST_IDLE: ;
      ST_KI: begin
        ctrl_o.mul_sel    = MUL_KI_ERR;
        ctrl_o.inner_load = 1'b1;
      end
      ST_KD: begin
        ctrl_o.mul_sel   = MUL_KD_CURV;
        ctrl_o.inner_add = 1'b1;
      end
      ST_IADD: ctrl_o.inner_add = 1'b1;
      ST_LO: begin
        ctrl_o.mul_sel  = MUL_KP_LO;
        ctrl_o.sum_load = 1'b1;
      end
      ST_HI: begin
        ctrl_o.mul_sel    = MUL_KP_HI;
        ctrl_o.sum_add_lo = 1'b1;
      end
      ST_HADD:  ctrl_o.sum_add_hi = 1'b1;
      ST_CLAMP: ctrl_o.commit = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/incremental_pid_step.sv @@
// Top level of the incremental PID step: registers, datapath and output stage.
// Sequence: an accepted input beat registers its error, then the sequencer
//   steps KI, KD, IADD, LO, HI, HADD and CLAMP, and commits when not stalled.
// The single shared 20x20 multiplier, used four times per item under the
//   sequencer, keeps in_stall_o high until the item is committed.
// Reset: asynchronous, active low; clears accumulator, error history, gains
//   (to zero) and the limit (to 32767); no clearing pass is needed.
module incremental_pid_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ipid_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ipid_pkg::GainW-1:0]           cfg_data_i,
  // input beat
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ipid_pkg::DataW-1:0]    setpoint_i,
  input  logic signed [ipid_pkg::DataW-1:0]    measured_i,
  // output beat
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ipid_pkg::DataW-1:0]    drive_o
);
  import ipid_pkg::*;

  // Configuration registers.
  logic [GainW-1:0]  prop_gain_q;
  logic [GainW-1:0]  integral_ratio_q;
  logic [GainW-1:0]  derivative_ratio_q;
  logic [LimitW-1:0] limit_magnitude_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q        <= '0;
      integral_ratio_q   <= '0;
      derivative_ratio_q <= '0;
      limit_magnitude_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PROP_GAIN:        prop_gain_q        <= cfg_data_i;
        REG_INTEGRAL_RATIO:   integral_ratio_q   <= cfg_data_i;
        REG_DERIVATIVE_RATIO: derivative_ratio_q <= cfg_data_i;
        REG_LIMIT_MAGNITUDE:  limit_magnitude_q  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  ctrl_t ctrl;
  logic  out_valid_q;
  logic  out_busy;
  logic  accept;

  assign out_busy = out_valid_q && out_stall_i;

  ipid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  assign in_stall_o = ctrl.busy;
  assign accept     = in_valid_i && !ctrl.busy;

  // Error history. The incremental update is regrouped as
  //   kp * ( 256*(e-e1) + ki*e + kd*(e - 2*e1 + e2) )
  // so each multiply stays narrow; the kp multiply is split in two halves.
  logic signed [ErrW-1:0]   err_q;
  logic signed [ErrW-1:0]   prev_err_q;
  logic signed [ErrW-1:0]   older_err_q;
  logic signed [Diff1W-1:0] diff1;
  logic signed [Diff2W-1:0] diff2;

  assign diff1 = Diff1W'(err_q) - Diff1W'(prev_err_q);
  assign diff2 = Diff2W'(err_q) - (Diff2W'(prev_err_q) <<< 1) + Diff2W'(older_err_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= ErrW'(setpoint_i) - ErrW'(measured_i);
    end
  end

  // Shared multiplier operand select.
  logic signed [InnerW-1:0] inner_q;
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [ProdW-1:0]  prod;

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_KI_ERR: begin
        mul_a = signed'({4'b0, integral_ratio_q});
        mul_b = MulW'(err_q);
      end
      MUL_KD_CURV: begin
        mul_a = signed'({4'b0, derivative_ratio_q});
        mul_b = MulW'(diff2);
      end
      MUL_KP_LO: begin
        mul_a = signed'({4'b0, prop_gain_q});
        mul_b = signed'({2'b0, inner_q[LoW-1:0]});
      end
      MUL_KP_HI: begin
        mul_a = signed'({4'b0, prop_gain_q});
        mul_b = MulW'(signed'(inner_q[InnerW-1:LoW]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ipid_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Inner sum: load the 256*(e-e1) term, then add the two ratio products.
  always_ff @(posedge clk_i) begin
    if (ctrl.inner_load) begin
      inner_q <= {{(InnerW-Diff1W-8){diff1[Diff1W-1]}}, diff1, 8'b0};
    end else if (ctrl.inner_add) begin
      inner_q <= inner_q + prod[InnerW-1:0];
    end
  end

  // Wide sum: accumulator plus kp times the inner sum, in two halves.
  logic signed [AccW-1:0] acc_q;
  logic signed [SumW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.sum_load) begin
      sum_q <= SumW'(acc_q);
    end else if (ctrl.sum_add_lo) begin
      sum_q <= sum_q + SumW'(prod);
    end else if (ctrl.sum_add_hi) begin
      sum_q <= sum_q + {prod[SumW-LoW-1:0], {LoW{1'b0}}};
    end
  end

  // Clamp to +/- limit in Q16.16.
  logic signed [SumW-1:0] bound;
  logic signed [AccW-1:0] acc_clamped;

  assign bound = signed'({{(SumW-LimitW-FracW){1'b0}}, limit_magnitude_q, {FracW{1'b0}}});

  always_comb begin
    priority if (sum_q > bound) begin
      acc_clamped = bound[AccW-1:0];
    end else if (sum_q < -bound) begin
      acc_clamped = AccW'(-bound);
    end else begin
      acc_clamped = sum_q[AccW-1:0];
    end
  end

  // Commit the update: advance the error history and load the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      prev_err_q  <= '0;
      older_err_q <= '0;
    end else if (ctrl.commit) begin
      acc_q       <= acc_clamped;
      prev_err_q  <= err_q;
      older_err_q <= prev_err_q;
    end
  end

  logic signed [DataW-1:0] drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Floor of the Q16.16 value is just its upper half.
  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      drive_q <= acc_clamped[AccW-1:FracW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

@@ rtl/ipid_checker.sv @@
// Port-level checks for the incremental PID step, bound to the top level.
module ipid_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ipid_pkg::DataW-1:0] drive_o
);
  import ipid_pkg::*;

  // A stalled output beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("output beat changed while stalled");

  // Clamping is symmetric, so the most negative code never shows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != {1'b1, {(DataW-1){1'b0}}})
    else $error("drive outside symmetric range");

  // An accepted input beat makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second beat while working");

  // The result cannot appear in the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind incremental_pid_step ipid_checker u_ipid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
